### rtl/rmts_pkg.sv
package rmts_pkg;

    localparam int unsigned MAX_TASKS_DEF = 8;
    localparam int unsigned IDX_W         = 6;   // holds any index up to 64 entries
    localparam int unsigned PERIOD_W      = 16;
    localparam int unsigned COST_W        = 16;
    localparam int unsigned READY_W       = 32;
    localparam int unsigned ADV_W         = 31;
    localparam int unsigned ACTIVE_W      = 4;
    localparam int unsigned SLOT_W        = 3;
    localparam int unsigned IN_TDATA_W    = 56;
    localparam int unsigned OUT_TDATA_W   = 40;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic signed [READY_W-1:0] READY_MAX = 32'sh7fff_ffff;
    localparam logic signed [READY_W-1:0] READY_MIN = 32'sh8000_0000;

    // running result of the selection pass, moved one cell per cycle
    typedef struct packed {
        logic                       found;
        logic [IDX_W-1:0]           idx;
        logic [PERIOD_W-1:0]        period;
        logic [COST_W-1:0]          cost;
        logic signed [READY_W-1:0]  min_ready;
    } t_carry;

    // update command broadcast to every cell
    typedef struct packed {
        logic               en;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [ADV_W-1:0]   delta;
    } t_upd;

    function automatic logic signed [READY_W-1:0] clamp34(input logic signed [33:0] v);
        logic signed [READY_W-1:0] r;
        if (v > 34'(READY_MAX)) begin
            r = READY_MAX;
        end else if (v < 34'(READY_MIN)) begin
            r = READY_MIN;
        end else begin
            r = v[READY_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/rmts_cell.sv
module rmts_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_active,
    input  logic                             i_load,
    input  logic [rmts_pkg::PERIOD_W-1:0]    i_period,
    input  logic [rmts_pkg::COST_W-1:0]      i_cost,
    input  logic [rmts_pkg::PERIOD_W-1:0]    i_wait,
    input  rmts_pkg::t_carry                 i_carry,
    input  rmts_pkg::t_upd                   i_upd,
    output rmts_pkg::t_carry                 o_carry
);

    logic [rmts_pkg::PERIOD_W-1:0]          r_period;
    logic [rmts_pkg::COST_W-1:0]            r_cost;
    logic signed [rmts_pkg::READY_W-1:0]    r_ready;
    rmts_pkg::t_carry                       r_carry;
    rmts_pkg::t_carry                       n_carry;
    logic signed [rmts_pkg::READY_W-1:0]    n_ready;
    logic                                   take;
    logic signed [33:0]                     sum_pick;
    logic signed [33:0]                     sum_idle;

    assign take = i_active && (r_ready <= 0)
                  && (!i_carry.found || (r_period < i_carry.period));

    always_comb begin
        n_carry = i_carry;
        if (take) begin
            n_carry.found  = 1'b1;
            n_carry.idx    = rmts_pkg::IDX_W'(INDEX);
            n_carry.period = r_period;
            n_carry.cost   = r_cost;
        end
        if (i_active && (r_ready < i_carry.min_ready)) begin
            n_carry.min_ready = r_ready;
        end
    end

    assign sum_pick = $signed({18'd0, r_period}) - $signed({18'd0, r_cost})
                      + 34'(r_ready);
    assign sum_idle = 34'(r_ready) - $signed({3'd0, i_upd.delta});

    always_comb begin
        n_ready = r_ready;
        if (i_upd.found && (i_upd.idx == rmts_pkg::IDX_W'(INDEX))) begin
            n_ready = rmts_pkg::clamp34(sum_pick);
        end else begin
            n_ready = rmts_pkg::clamp34(sum_idle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_cost   <= '0;
            r_ready  <= '0;
        end else if (i_load) begin
            r_period <= i_period;
            r_cost   <= i_cost;
            r_ready  <= $signed({16'd0, i_wait});
        end else if (i_upd.en && i_active) begin
            r_ready  <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

### rtl/rate_monotonic_task_selector.sv
// Rate-monotonic task selector over a row of task cells. A load transfer
// (tuser 0) writes one entry and answers with an all-zero result in the next
// cycle. In a step transfer (tuser 1) the search for the ready task with the
// smallest period walks down the cell chain one cell a cycle, then, once the
// result register is free, every active cell updates its ready time. One item is
// in work at a time; a load is taken again in the cycle after the previous item
// finishes, provided the result register is free or being drained. The table
// clears on reset and active_tasks resets to 8.
module rate_monotonic_task_selector #(
    parameter int unsigned MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rmts_pkg::ACTIVE_W-1:0]       i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // task_slot, task_period, task_cost, initial_wait, zero pad
    input  logic [rmts_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // command
    input  logic [0:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // chosen_slot, time_advance, zero pad
    output logic [rmts_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // ran
    output logic [0:0]                          o_m_tuser
);

    localparam int unsigned CNT_W = $clog2(MAX_TASKS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    localparam rmts_pkg::t_carry CARRY_INIT = '{
        found:     1'b0,
        idx:       '0,
        period:    '0,
        cost:      '0,
        min_ready: rmts_pkg::READY_MAX
    };

    logic [1:0]                             r_state;
    logic [CNT_W-1:0]                       r_cnt;
    logic [rmts_pkg::ACTIVE_W-1:0]          r_active;
    logic                                   r_out_valid;
    logic                                   r_out_ran;
    logic [rmts_pkg::SLOT_W-1:0]            r_out_slot;
    logic [rmts_pkg::ADV_W-1:0]             r_out_adv;

    logic                                   out_free;
    logic                                   s_accept;
    logic                                   load_accept;
    logic                                   upd_fire;
    logic [rmts_pkg::SLOT_W-1:0]            in_slot;
    logic [rmts_pkg::PERIOD_W-1:0]          in_period;
    logic [rmts_pkg::COST_W-1:0]            in_cost;
    logic [rmts_pkg::PERIOD_W-1:0]          in_wait;
    logic [rmts_pkg::ADV_W-1:0]             step_adv;
    rmts_pkg::t_carry                       carry_in  [MAX_TASKS];
    rmts_pkg::t_carry                       carry_out [MAX_TASKS];
    rmts_pkg::t_carry                       result;
    rmts_pkg::t_upd                         upd;

    assign in_slot   = i_s_tdata[2:0];
    assign in_period = i_s_tdata[18:3];
    assign in_cost   = i_s_tdata[34:19];
    assign in_wait   = i_s_tdata[50:35];

    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE) && out_free;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign load_accept = s_accept && (i_s_tuser[0] == rmts_pkg::CMD_LOAD);
    assign upd_fire    = (r_state == ST_UPD) && out_free;

    assign result = carry_out[MAX_TASKS-1];

    // with nothing active the step leaves the table alone and reports zero
    assign step_adv = result.found ? rmts_pkg::ADV_W'(result.cost)
                    : (r_active == '0) ? '0
                    : result.min_ready[rmts_pkg::ADV_W-1:0];

    assign upd.en    = upd_fire;
    assign upd.found = result.found;
    assign upd.idx   = result.idx;
    assign upd.delta = step_adv;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        logic cell_active;
        logic cell_load;

        assign cell_active = ({28'd0, r_active} > 32'(k));
        assign cell_load   = load_accept && (32'(in_slot) == 32'(k));

        if (k == 0) begin : g_head
            assign carry_in[k] = CARRY_INIT;
        end else begin : g_link
            assign carry_in[k] = carry_out[k-1];
        end

        rmts_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (cell_active),
            .i_load   (cell_load),
            .i_period (in_period),
            .i_cost   (in_cost),
            .i_wait   (in_wait),
            .i_carry  (carry_in[k]),
            .i_upd    (upd),
            .o_carry  (carry_out[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= rmts_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept && (i_s_tuser[0] == rmts_pkg::CMD_STEP)) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    // the last cell holds the answer once the pass has run the chain
                    if (r_cnt == CNT_W'(MAX_TASKS - 1)) begin
                        r_state <= ST_UPD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_accept || upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_accept) begin
            r_out_ran  <= 1'b0;
            r_out_slot <= '0;
            r_out_adv  <= '0;
        end else if (upd_fire) begin
            r_out_ran  <= result.found;
            r_out_slot <= result.found ? result.idx[rmts_pkg::SLOT_W-1:0] : '0;
            r_out_adv  <= step_adv;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_ran;
    assign o_m_tdata  = {6'd0, r_out_adv, r_out_slot};

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_accept |=> o_m_tvalid)
        else $error("load transfer produced no result");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_tready)
        else $error("input taken while a step is in work");

    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (o_m_tvalid && (r_state == ST_IDLE)))
        else $error("step update did not deliver a result");

endmodule
